FILE: rtl/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg: shared definitions for the grid maze search block
// Register indexes, field widths, default grid limits and the queue entry.
// ----------------------------------------------------------------------------
package gmb_pkg;

  localparam int REG_W = 7;
  localparam int IDX_W = 2 * REG_W;
  localparam int LEN_W = 12;
  localparam int CFG_IDX_W = 3;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 3'd0,
    REG_GRID_COLS = 3'd1,
    REG_START_ROW = 3'd2,
    REG_START_COL = 3'd3,
    REG_GOAL_ROW  = 3'd4,
    REG_GOAL_COL  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [REG_W-1:0] row;
    logic [REG_W-1:0] col;
    logic [LEN_W-1:0] steps;
  } qent_t;

endpackage

FILE: rtl/grid_maze_bfs_distance.sv
// ----------------------------------------------------------------------------
// grid_maze_bfs_distance: shortest path length through a loaded maze grid
// Cells stream in row-major order; the last cell starts a breadth-first
// search from the start cell, which yields one distance result.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle. The item that carries last_cell stalls the
// input while the search runs: a clearing pass over the visited store,
// seeding of the start cell, and then, for each expanded cell, one queue
// read, one goal compare, and a scan in which the four neighbours flow
// through the shared index multiplier and the wall and visited memories.
// The search is skipped when the start or goal lies outside the grid. The
// result sits in an output register, so loading of the next grid can start
// while it waits.
module grid_maze_bfs_distance
  import gmb_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 cell_open,
  input  logic                 last_cell,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [LEN_W-1:0]     path_length,
  output logic                 goal_reached
);

  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CW       = $clog2(CELLS);
  localparam int REG_MAX  = (1 << REG_W) - 1;
  localparam int ROWS_CAP = (MAX_ROWS > REG_MAX) ? REG_MAX : MAX_ROWS;
  localparam int COLS_CAP = (MAX_COLS > REG_MAX) ? REG_MAX : MAX_COLS;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_START, S_SEED, S_POP, S_CUR, S_NBR, S_DONE
  } state_t;

  state_t state;

  logic [REG_W-1:0] grid_rows, grid_cols, start_row, start_col, goal_row, goal_col;

  logic             wall_map [CELLS];
  logic             visited  [CELLS];
  qent_t            frontier [CELLS];

  logic [IDX_W-1:0] load_index;
  logic [IDX_W-1:0] clr;
  logic [IDX_W-1:0] head, tail;
  logic [2:0]       nbr_k;
  qent_t            q_rd;

  logic             a_valid;
  logic [IDX_W-1:0] a_idx;
  logic [REG_W-1:0] a_row, a_col;
  logic             b_valid;
  logic [IDX_W-1:0] b_idx;
  logic [REG_W-1:0] b_row, b_col;
  logic             wall_q, vis_q;

  logic             res_reached;
  logic [LEN_W-1:0] res_len;

  logic [REG_W-1:0] rows, cols;
  logic [IDX_W-1:0] total;
  logic             start_in, goal_in;
  logic [REG_W:0]   nr, nc;
  logic             n_in;
  logic [REG_W-1:0] m_row, m_col;
  logic [IDX_W-1:0] m_idx;
  logic             in_take, b_take;
  logic             vis_we, vis_wdata;
  logic [IDX_W-1:0] vis_waddr;
  logic [LEN_W-1:0] d_next;

  assign rows  = (grid_rows > REG_W'(ROWS_CAP)) ? REG_W'(ROWS_CAP) : grid_rows;
  assign cols  = (grid_cols > REG_W'(COLS_CAP)) ? REG_W'(COLS_CAP) : grid_cols;
  assign total = IDX_W'(rows * cols);

  assign start_in = (start_row != '0) && (start_row <= rows) &&
                    (start_col != '0) && (start_col <= cols);
  assign goal_in  = (goal_row != '0) && (goal_row <= rows) &&
                    (goal_col != '0) && (goal_col <= cols);

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    nr = {1'b0, q_rd.row};
    nc = {1'b0, q_rd.col};
    case (nbr_k)
      3'd0:    nr = {1'b0, q_rd.row} + 1'b1;
      3'd1:    nc = {1'b0, q_rd.col} + 1'b1;
      3'd2:    nr = {1'b0, q_rd.row} - 1'b1;
      3'd3:    nc = {1'b0, q_rd.col} - 1'b1;
      default: nr = {1'b0, q_rd.row};
    endcase
  end

  assign n_in = (nr != '0) && (nr <= {1'b0, rows}) && (nc != '0) && (nc <= {1'b0, cols});

  // The one index multiplier serves both the start cell and every neighbour.
  always_comb begin
    if (state == S_START) begin
      m_row = start_row - 1'b1;
      m_col = start_col - 1'b1;
    end else begin
      m_row = REG_W'(nr - 1'b1);
      m_col = REG_W'(nc - 1'b1);
    end
  end

  assign m_idx = IDX_W'(m_row * cols) + IDX_W'(m_col);

  assign b_take = b_valid && wall_q && !vis_q;
  assign d_next = (q_rd.steps == LEN_MAX) ? LEN_MAX : q_rd.steps + 1'b1;

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = b_idx;
    vis_wdata = 1'b1;
    if (state == S_CLEAR && clr != total) begin
      vis_we    = 1'b1;
      vis_waddr = clr;
      vis_wdata = 1'b0;
    end else if (state == S_SEED) begin
      vis_we    = 1'b1;
      vis_waddr = a_idx;
    end else if (b_take) begin
      vis_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && load_index < total) begin
      wall_map[CW'(load_index)] <= cell_open;
    end
    wall_q <= wall_map[CW'(a_idx)];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      visited[CW'(vis_waddr)] <= vis_wdata;
    end
    vis_q <= visited[CW'(a_idx)];
  end

  always_ff @(posedge clk) begin
    if (state == S_SEED) begin
      frontier[CW'(tail)] <= '{row: start_row, col: start_col, steps: '0};
    end else if (b_take) begin
      frontier[CW'(tail)] <= '{row: b_row, col: b_col, steps: d_next};
    end
    if (state == S_POP) begin
      q_rd <= frontier[CW'(head)];
    end
  end

  always_ff @(posedge clk) begin
    a_idx <= m_idx;
    a_row <= REG_W'(nr);
    a_col <= REG_W'(nc);
    b_idx <= a_idx;
    b_row <= a_row;
    b_col <= a_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= (state == S_NBR) && (nbr_k < 3'd4) && n_in;
      b_valid <= a_valid && (a_idx < load_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= REG_W'(1);
      grid_cols <= REG_W'(1);
      start_row <= REG_W'(1);
      start_col <= REG_W'(1);
      goal_row  <= REG_W'(1);
      goal_col  <= REG_W'(1);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GRID_ROWS: grid_rows <= cfg_data;
        REG_GRID_COLS: grid_cols <= cfg_data;
        REG_START_ROW: start_row <= cfg_data;
        REG_START_COL: start_col <= cfg_data;
        REG_GOAL_ROW:  goal_row  <= cfg_data;
        REG_GOAL_COL:  goal_col  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      load_index   <= '0;
      clr          <= '0;
      head         <= '0;
      tail         <= '0;
      nbr_k        <= '0;
      res_reached  <= 1'b0;
      res_len      <= '0;
      out_valid    <= 1'b0;
      path_length  <= '0;
      goal_reached <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (b_take) begin
        tail <= tail + 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            if (load_index < total) begin
              load_index <= load_index + 1'b1;
            end
            if (last_cell) begin
              clr   <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          if (clr == total) begin
            state <= S_START;
          end else begin
            clr <= clr + 1'b1;
          end
        end
        S_START: begin
          res_reached <= 1'b0;
          res_len     <= '0;
          head        <= '0;
          tail        <= '0;
          if (start_in && goal_in) begin
            state <= S_SEED;
          end else begin
            state <= S_DONE;
          end
        end
        S_SEED: begin
          tail  <= IDX_W'(1);
          state <= S_POP;
        end
        S_POP: begin
          if (head == tail) begin
            state <= S_DONE;
          end else begin
            head  <= head + 1'b1;
            state <= S_CUR;
          end
        end
        S_CUR: begin
          if (q_rd.row == goal_row && q_rd.col == goal_col) begin
            res_reached <= 1'b1;
            res_len     <= q_rd.steps;
            state       <= S_DONE;
          end else begin
            nbr_k <= '0;
            state <= S_NBR;
          end
        end
        S_NBR: begin
          if (nbr_k == 3'd5) begin
            state <= S_POP;
          end else begin
            nbr_k <= nbr_k + 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            path_length  <= res_len;
            goal_reached <= res_reached;
            load_index   <= '0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed the tail");

  a_check_in_nbr: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> state == S_NBR)
    else $error("neighbour check outside neighbour scan");

  a_unreached_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !goal_reached |-> path_length == '0)
    else $error("unreached result with nonzero length");

  a_cur_after_pop: assert property (@(posedge clk) disable iff (rst)
    state == S_CUR |-> $past(state) == S_POP)
    else $error("goal compare without a queue read");

endmodule
